// File: rtl/kmc_pkg.sv
// Katakana mora counter: shared types, constants and the character classifier.
// Depends on nothing; every other file of the block refers to it by scoped names.
package kmc_pkg;

    // Field widths
    localparam int CHAR_WIDTH   = 16;
    localparam int ACCENT_WIDTH = 8;
    localparam int COUNT_WIDTH  = 8;
    localparam int STATUS_WIDTH = 3;

    // Defaults for the top-level parameters
    localparam int MORA_COUNT_MAX_DEFAULT = 255;
    localparam int QUEUE_DEPTH_DEFAULT    = 4;

    // Code points
    localparam logic [CHAR_WIDTH-1:0] KATAKANA_FIRST = 16'h30A1;
    localparam logic [CHAR_WIDTH-1:0] KATAKANA_LAST  = 16'h30F4;
    localparam logic [CHAR_WIDTH-1:0] LONG_MARK      = 16'h30FC;
    localparam logic [CHAR_WIDTH-1:0] SMALL_TSU      = 16'h30C3;
    localparam logic [CHAR_WIDTH-1:0] SMALL_WA       = 16'h30EE;
    localparam logic [CHAR_WIDTH-1:0] KANA_KU        = 16'h30AF;
    localparam logic [CHAR_WIDTH-1:0] KANA_GU        = 16'h30B0;
    localparam logic [CHAR_WIDTH-1:0] SMALL_A        = 16'h30A1;
    localparam logic [CHAR_WIDTH-1:0] SMALL_I        = 16'h30A3;
    localparam logic [CHAR_WIDTH-1:0] SMALL_U        = 16'h30A5;
    localparam logic [CHAR_WIDTH-1:0] SMALL_E        = 16'h30A7;
    localparam logic [CHAR_WIDTH-1:0] SMALL_O        = 16'h30A9;
    localparam logic [CHAR_WIDTH-1:0] SMALL_YA       = 16'h30E3;
    localparam logic [CHAR_WIDTH-1:0] SMALL_YU       = 16'h30E5;
    localparam logic [CHAR_WIDTH-1:0] SMALL_YO       = 16'h30E7;

    // Class of one character, decided in the front part
    typedef enum logic [2:0] {
        CLS_NOT_KANA,
        CLS_PLAIN,
        CLS_KU_GU,
        CLS_SMALL_TSU,
        CLS_SMALL_VOWEL,
        CLS_SMALL_WA
    } char_class_t;

    // Kind of the previous character, kept in the back part
    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_KU_GU,
        KIND_SMALL,
        KIND_SMALL_TSU
    } prev_kind_t;

    // Result status codes
    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK          = 3'd0,
        STATUS_NOT_KANA    = 3'd1,
        STATUS_SMALL_PAIR  = 3'd2,
        STATUS_MISPLACE_WA = 3'd3,
        STATUS_BAD_ACCENT  = 3'd4
    } status_t;

    // One classified beat travelling from front to back
    typedef struct packed {
        char_class_t              cls;
        logic                     last_char;
        logic [ACCENT_WIDTH-1:0]  accent_pos;
    } front_item_t;

    localparam int ITEM_WIDTH = $bits(front_item_t);

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Map a code point to its class
    function automatic char_class_t classify(input logic [CHAR_WIDTH-1:0] c);
        logic katakana;
        logic small_vowel;
        char_class_t cls;
        katakana = ((c >= KATAKANA_FIRST) && (c <= KATAKANA_LAST)) || (c == LONG_MARK);
        small_vowel = (c == SMALL_A) || (c == SMALL_I) || (c == SMALL_U) ||
                      (c == SMALL_E) || (c == SMALL_O) || (c == SMALL_YA) ||
                      (c == SMALL_YU) || (c == SMALL_YO);
        if (!katakana)
            cls = CLS_NOT_KANA;
        else if (c == SMALL_TSU)
            cls = CLS_SMALL_TSU;
        else if (c == SMALL_WA)
            cls = CLS_SMALL_WA;
        else if (small_vowel)
            cls = CLS_SMALL_VOWEL;
        else if ((c == KANA_KU) || (c == KANA_GU))
            cls = CLS_KU_GU;
        else
            cls = CLS_PLAIN;
        return cls;
    endfunction

endpackage

// File: rtl/kmc_ifs.sv
// Katakana mora counter: valid/ready channel interfaces for characters and results.
// Depends on kmc_pkg for field widths.
interface kmc_in_if;
    logic                              valid;
    logic                              ready;
    logic [kmc_pkg::CHAR_WIDTH-1:0]    char_code;
    logic                              last_char;
    logic [kmc_pkg::ACCENT_WIDTH-1:0]  accent_pos;

    modport source (output valid, output char_code, output last_char, output accent_pos,
                    input ready);
    modport sink (input valid, input char_code, input last_char, input accent_pos,
                  output ready);
endinterface

interface kmc_out_if;
    logic                              valid;
    logic                              ready;
    logic [kmc_pkg::COUNT_WIDTH-1:0]   morae;
    logic [kmc_pkg::STATUS_WIDTH-1:0]  status;
    logic                              word_end;

    modport source (output valid, output morae, output status, output word_end,
                    input ready);
    modport sink (input valid, input morae, input status, input word_end,
                  output ready);
endinterface

// File: rtl/kmc_front.sv
// Katakana mora counter front part: accepts characters, classifies them, registers the beat.
// Depends on kmc_pkg and kmc_ifs.
module kmc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    kmc_in_if.sink                char_in,
    output kmc_pkg::front_item_t  item,
    output logic                  item_valid,
    input  logic                  item_ready
);

    logic                  valid_reg;
    logic                  valid_next;
    kmc_pkg::front_item_t  item_reg;
    kmc_pkg::front_item_t  item_next;
    logic                  take;

    // Stage register frees up whenever the queue takes its beat
    assign char_in.ready = !valid_reg || item_ready;
    assign take          = char_in.valid && char_in.ready;

    always_comb
    begin
        item_next.cls        = kmc_pkg::classify(char_in.char_code);
        item_next.last_char  = char_in.last_char;
        item_next.accent_pos = char_in.accent_pos;
        valid_next           = take || (valid_reg && !item_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// File: rtl/kmc_queue.sv
// Katakana mora counter: short register queue between the front and back parts.
// Depends on kmc_pkg.
module kmc_queue #(
    parameter int DEPTH = kmc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  kmc_pkg::front_item_t    push_item,
    input  logic                    push_valid,
    output logic                    push_ready,
    output kmc_pkg::front_item_t    pop_item,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output kmc_pkg::queue_status_t  status
);

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

    kmc_pkg::front_item_t  slot_reg [DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg;
    logic [PTR_WIDTH-1:0]  wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg;
    logic [PTR_WIDTH-1:0]  rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg;
    logic [CNT_WIDTH-1:0]  count_next;
    logic                  push;
    logic                  pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign push         = push_valid && push_ready;
    assign pop          = pop_valid && pop_ready;
    assign pop_item     = slot_reg[rd_ptr_reg];

    // Pointer wrap works for any depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: rtl/kmc_back.sv
// Katakana mora counter back part: word state, error latch, mora count, result register.
// Depends on kmc_pkg and kmc_ifs.
module kmc_back #(
    parameter int MORA_COUNT_MAX = kmc_pkg::MORA_COUNT_MAX_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kmc_pkg::front_item_t  item,
    input  logic                  item_valid,
    output logic                  item_ready,
    kmc_out_if.source             result_out
);

    localparam int COUNT_FULL = (1 << kmc_pkg::COUNT_WIDTH) - 1;
    localparam int LIMIT_INT  = (MORA_COUNT_MAX > COUNT_FULL) ? COUNT_FULL : MORA_COUNT_MAX;
    localparam logic [kmc_pkg::COUNT_WIDTH-1:0] COUNT_LIMIT = kmc_pkg::COUNT_WIDTH'(LIMIT_INT);

    kmc_pkg::prev_kind_t                kind_reg;
    kmc_pkg::prev_kind_t                kind_next;
    logic [kmc_pkg::COUNT_WIDTH-1:0]    total_reg;
    logic [kmc_pkg::COUNT_WIDTH-1:0]    total_next;
    kmc_pkg::status_t                   error_reg;
    kmc_pkg::status_t                   error_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [kmc_pkg::COUNT_WIDTH-1:0]    out_count_reg;
    kmc_pkg::status_t                   out_status_reg;
    logic                               out_end_reg;

    kmc_pkg::prev_kind_t                kind_new;
    kmc_pkg::status_t                   err_char;
    kmc_pkg::status_t                   err_word;
    logic [kmc_pkg::COUNT_WIDTH-1:0]    total_new;
    logic                               counts;
    logic                               prev_small;
    logic                               take;

    // Result register parts the queue from the consumer
    assign item_ready = !out_valid_reg || result_out.ready;
    assign take       = item_valid && item_ready;

    // Per-character checks
    always_comb
    begin
        prev_small = (kind_reg == kmc_pkg::KIND_SMALL) || (kind_reg == kmc_pkg::KIND_SMALL_TSU);
        err_char   = kmc_pkg::STATUS_OK;
        kind_new   = kmc_pkg::KIND_PLAIN;
        counts     = 1'b1;
        unique case (item.cls)
            kmc_pkg::CLS_NOT_KANA:
            begin
                err_char = kmc_pkg::STATUS_NOT_KANA;
            end
            kmc_pkg::CLS_SMALL_TSU:
            begin
                if (kind_reg == kmc_pkg::KIND_SMALL_TSU)
                    err_char = kmc_pkg::STATUS_SMALL_PAIR;
                kind_new = kmc_pkg::KIND_SMALL_TSU;
            end
            kmc_pkg::CLS_SMALL_VOWEL:
            begin
                if (prev_small)
                    err_char = kmc_pkg::STATUS_SMALL_PAIR;
                kind_new = kmc_pkg::KIND_SMALL;
                counts   = 1'b0;
            end
            kmc_pkg::CLS_SMALL_WA:
            begin
                if (prev_small)
                    err_char = kmc_pkg::STATUS_SMALL_PAIR;
                else if (kind_reg != kmc_pkg::KIND_KU_GU)
                    err_char = kmc_pkg::STATUS_MISPLACE_WA;
                kind_new = kmc_pkg::KIND_SMALL;
                counts   = 1'b0;
            end
            kmc_pkg::CLS_KU_GU:
            begin
                kind_new = kmc_pkg::KIND_KU_GU;
            end
            kmc_pkg::CLS_PLAIN:
            begin
                kind_new = kmc_pkg::KIND_PLAIN;
            end
            default:
            begin
                kind_new = kmc_pkg::KIND_PLAIN;
            end
        endcase

        // Saturating count
        total_new = (counts && (total_reg < COUNT_LIMIT)) ? total_reg + 1'b1 : total_reg;

        // First error wins; accent check only at the end of the word
        err_word = (error_reg != kmc_pkg::STATUS_OK) ? error_reg : err_char;
        if (item.last_char && (item.accent_pos > total_new) &&
            (err_word == kmc_pkg::STATUS_OK))
            err_word = kmc_pkg::STATUS_BAD_ACCENT;

        // Word state; cleared after the last character
        kind_next  = kind_reg;
        total_next = total_reg;
        error_next = error_reg;
        if (take)
        begin
            if (item.last_char)
            begin
                kind_next  = kmc_pkg::KIND_PLAIN;
                total_next = '0;
                error_next = kmc_pkg::STATUS_OK;
            end
            else
            begin
                kind_next  = kind_new;
                total_next = total_new;
                error_next = err_word;
            end
        end

        out_valid_next = take || (out_valid_reg && !result_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= kmc_pkg::KIND_PLAIN;
            total_reg     <= '0;
            error_reg     <= kmc_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            total_reg     <= total_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_count_reg  <= total_new;
            out_status_reg <= err_word;
            out_end_reg    <= item.last_char;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.morae    = out_count_reg;
    assign result_out.status   = out_status_reg;
    assign result_out.word_end = out_end_reg;

endmodule

// File: rtl/katakana_mora_counter_unit.sv
// Katakana mora counter top level: front classifier, queue, back counter, assertions.
// Depends on kmc_pkg, kmc_ifs, kmc_front, kmc_queue and kmc_back.

// Takes one katakana code point per beat (with a last-character flag and the word's
// accent type) and returns one result per character: the mora count so far, the first
// error of the word and a word_end flag that marks the final status. One character is
// accepted every clock cycle while the queue has room; a character passes through the
// classifier register, a queue slot and the result register before its result is
// offered. The queue of QUEUE_DEPTH beats lets the input keep flowing while the result
// side is stalled, until the queue fills. The count saturates at the smaller of
// MORA_COUNT_MAX and 255.
module katakana_mora_counter_unit #(
    parameter int MORA_COUNT_MAX = kmc_pkg::MORA_COUNT_MAX_DEFAULT,
    parameter int QUEUE_DEPTH    = kmc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    kmc_in_if.sink      char_in,
    kmc_out_if.source   result_out
);

    kmc_pkg::front_item_t    front_item;
    logic                    front_valid;
    logic                    front_ready;
    kmc_pkg::front_item_t    back_item;
    logic                    back_valid;
    logic                    back_ready;
    kmc_pkg::queue_status_t  q_status;

    kmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    kmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (back_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .status     (q_status)
    );

    kmc_back #(
        .MORA_COUNT_MAX (MORA_COUNT_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .result_out (result_out)
    );

    // Queue never claims to be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty together");

    // A full queue stalls the front stage
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !front_ready)
        else $error("queue accepted a beat while full");

    // Status codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.status <= kmc_pkg::STATUS_BAD_ACCENT))
        else $error("result status out of range");

    // A bad accent is only reported on the closing beat of a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && (result_out.status == kmc_pkg::STATUS_BAD_ACCENT))
        |-> result_out.word_end)
        else $error("bad accent reported before word end");

endmodule
